>>> design/secp256k1_field_alu_unit_defines.svh
// Assertion macros shared by the field unit.
`ifndef SECP256K1_FIELD_ALU_UNIT_DEFINES_SVH
`define SECP256K1_FIELD_ALU_UNIT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SFA_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("field unit assertion failed");
// Next-cycle implication.
`define SFA_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("field unit assertion failed");
`else
`define SFA_ASSERT_IMPL(lbl, clk, rst, a, b)
`define SFA_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

>>> design/sfa_pkg.sv
package sfa_pkg;

  // Operation selector codes as they arrive on the kind field.
  localparam logic [2:0] KIND_MUL  = 3'd0;
  localparam logic [2:0] KIND_SQR  = 3'd1;
  localparam logic [2:0] KIND_ADD  = 3'd2;
  localparam logic [2:0] KIND_NEG  = 3'd3;
  localparam logic [2:0] KIND_SMUL = 3'd4;
  localparam logic [2:0] KIND_NORM = 3'd5;

  // Field constants in radix 2^52.
  localparam logic [63:0] M52     = 64'hFFFFFFFFFFFFF;
  localparam logic [63:0] M48     = 64'h0FFFFFFFFFFFF;
  localparam logic [63:0] P_LIMB0 = 64'hFFFFEFFFFFC2F;
  localparam logic [63:0] P_LIMB4 = 64'hFFFFFFFFFFFF;
  // Low parts of the fold constants; the powers of two are done by shifts.
  localparam logic [13:0] FOLD_HI_LOW = 14'h3D10;
  localparam logic [9:0]  FOLD_LO_LOW = 10'h3D1;

  // Default queue depth and back-end pipeline length.
  localparam int Q_DEPTH   = 4;
  localparam int BK_STAGES = 20;

  // Decoded operation carried from front to back.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL,
    OP_SQR,
    OP_ADD,
    OP_NEG,
    OP_SMUL,
    OP_NORM
  } op_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] x_limb0;
    logic [63:0] x_limb1;
    logic [63:0] x_limb2;
    logic [63:0] x_limb3;
    logic [63:0] x_limb4;
    logic [63:0] y_limb0;
    logic [63:0] y_limb1;
    logic [63:0] y_limb2;
    logic [63:0] y_limb3;
    logic [63:0] y_limb4;
    logic [7:0]  scalar;
  } alu_in_t;

  typedef struct packed {
    logic [63:0] res_limb0;
    logic [63:0] res_limb1;
    logic [63:0] res_limb2;
    logic [63:0] res_limb3;
    logic [63:0] res_limb4;
    logic        is_zero;
    logic        is_odd;
  } alu_res_t;

  // Classified item held in the queue.
  typedef struct packed {
    op_t               op;
    logic [4:0][63:0]  x;
    logic [4:0][63:0]  y;
    logic [7:0]        scalar;
  } work_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> design/sfa_front.sv
module sfa_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  sfa_pkg::alu_in_t item,
  input  sfa_pkg::q_stat_t q_stat,
  output logic            busy,
  output logic            push,
  output sfa_pkg::work_t  push_data
);
  import sfa_pkg::*;

  logic  valid;
  work_t held;
  work_t held_next;
  logic  take;

  // The front stage stalls only when it holds an item the queue cannot take.
  assign busy      = valid & q_stat.full;
  assign take      = start & ~busy;
  assign push      = valid & ~q_stat.full;
  assign push_data = held;

  // Classify the selector and gather the limbs into arrays.
  always_comb begin
    held_next.x      = {item.x_limb4, item.x_limb3, item.x_limb2, item.x_limb1, item.x_limb0};
    held_next.y      = {item.y_limb4, item.y_limb3, item.y_limb2, item.y_limb1, item.y_limb0};
    held_next.scalar = item.scalar;
    case (item.kind)
      KIND_MUL:  held_next.op = OP_MUL;
      KIND_SQR:  held_next.op = OP_SQR;
      KIND_ADD:  held_next.op = OP_ADD;
      KIND_NEG:  held_next.op = OP_NEG;
      KIND_SMUL: held_next.op = OP_SMUL;
      KIND_NORM: held_next.op = OP_NORM;
      default:   held_next.op = OP_NONE;
    endcase
  end

  // Holding register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  // Payload loads on every transfer.
  always_ff @(posedge clk) begin
    if (take) begin
      held <= held_next;
    end
  end

endmodule

>>> design/sfa_queue.sv
module sfa_queue #(
  parameter int DEPTH = sfa_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfa_pkg::work_t   push_data,
  output sfa_pkg::q_stat_t q_stat,
  output logic             pop,
  output sfa_pkg::work_t   head
);
  import sfa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  // The back end never stalls, so the head leaves as soon as it is there.
  assign pop  = ~q_stat.empty;
  assign head = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/sfa_back.sv
module sfa_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sfa_pkg::work_t    in_work,
  output logic              done,
  output sfa_pkg::alu_res_t result
);
  import sfa_pkg::*;

  // Working record carried down the pipeline; each stage uses a few fields.
  typedef struct packed {
    op_t                    op;
    logic [4:0][63:0]       x;
    logic [4:0][63:0]       y;
    logic [7:0]             scalar;
    logic [4:0][63:0]       lmb;
    logic [24:0][3:0][63:0] pp;
    logic [24:0][127:0]     prod;
    logic [9:0][127:0]      col;
    logic [9:0][63:0]       t;
    logic [127:0]           acc;
  } stg_t;

  // Work done by pipeline stage s.
  function automatic stg_t stage_fn(input int s, input stg_t d);
    stg_t         q;
    logic [127:0] c;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  n;
    logic [8:0]   m1;
    logic         is_mul;
    logic         keep;
    int           p;
    int           k;
    q      = d;
    is_mul = (d.op == OP_MUL) || (d.op == OP_SQR);
    m1     = {1'b0, d.scalar} + 9'd1;
    if (s == 0) begin
      // Partial products of 32 bits and the short operations.
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          p = i * 5 + j;
          a = '0;
          b = '0;
          if (d.op == OP_MUL) begin
            a = d.x[i];
            b = d.y[j];
          end else if (d.op == OP_SQR && i < j) begin
            a = {d.x[i][62:0], 1'b0};
            b = d.x[j];
          end else if (d.op == OP_SQR && i == j) begin
            a = d.x[i];
            b = d.x[i];
          end
          q.pp[p][0] = a[31:0] * b[31:0];
          q.pp[p][1] = a[31:0] * b[63:32];
          q.pp[p][2] = a[63:32] * b[31:0];
          q.pp[p][3] = a[63:32] * b[63:32];
        end
      end
      for (int i = 0; i < 5; i++) begin
        case (d.op)
          OP_ADD:  q.lmb[i] = d.x[i] + d.y[i];
          OP_SMUL: q.lmb[i] = d.x[i] * d.scalar;
          OP_NORM: q.lmb[i] = d.x[i];
          OP_NEG: begin
            if (i == 0) begin
              q.lmb[i] = P_LIMB0 * m1 - d.x[i];
            end else if (i == 4) begin
              q.lmb[i] = M48 * m1 - d.x[i];
            end else begin
              q.lmb[i] = M52 * m1 - d.x[i];
            end
          end
          default: q.lmb[i] = '0;
        endcase
      end
    end else if (s == 1) begin
      // Full 128-bit products.
      for (int i = 0; i < 25; i++) begin
        q.prod[i] = {64'b0, d.pp[i][0]} + {32'b0, d.pp[i][1], 32'b0}
                  + {32'b0, d.pp[i][2], 32'b0} + {d.pp[i][3], 64'b0};
      end
    end else if (s == 2) begin
      // Column sums, wrapping at 128 bits.
      q.col = '0;
      q.acc = '0;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          q.col[i + j] = q.col[i + j] + d.prod[i * 5 + j];
        end
      end
    end else if (s <= 11) begin
      // One column of the carry chain per stage.
      if (is_mul) begin
        k      = s - 3;
        c      = d.col[k] + d.acc;
        q.t[k] = {12'b0, c[51:0]};
        q.acc  = {52'b0, c[127:52]};
        if (k == 8) begin
          q.t[9] = c[115:52];
        end
      end
    end else if (s == 12) begin
      // Fold products of the upper columns.
      if (is_mul) begin
        for (int i = 5; i < 10; i++) begin
          q.col[i] = ({64'b0, d.t[i]} << 36) + {64'b0, d.t[i]} * FOLD_HI_LOW;
        end
        q.acc = '0;
      end
    end else if (s <= 17) begin
      // Fold chain, one limb per stage.
      if (is_mul) begin
        k = s - 13;
        c = d.acc + {64'b0, d.t[k]} + d.col[k + 5];
        if (k < 4) begin
          q.lmb[k] = {12'b0, c[51:0]};
          q.acc    = {52'b0, c[127:52]};
        end else begin
          q.lmb[k] = {16'b0, c[47:0]};
          q.acc    = {48'b0, c[127:48]};
        end
      end
    end else if (s == 18) begin
      if (is_mul) begin
        q.acc = (d.acc << 32) + d.acc * FOLD_LO_LOW;
      end
    end else begin
      if (is_mul) begin
        c        = {64'b0, d.lmb[0]} + d.acc;
        q.lmb[0] = {12'b0, c[51:0]};
        q.lmb[1] = d.lmb[1] + c[115:52];
      end
    end

    // Normalize runs over stages three to seven with a 64-bit carry.
    if (d.op == OP_NORM) begin
      n = d.acc[63:0];
      if (s == 3) begin
        n        = d.lmb[0];
        q.lmb[0] = n & M52;
        n        = (n >> 52) + d.lmb[1];
        q.lmb[1] = n & M52;
        n        = (n >> 52) + d.lmb[2];
        q.lmb[2] = n & M52;
        q.acc    = {64'b0, n};
      end else if (s == 4) begin
        n        = (n >> 52) + d.lmb[3];
        q.lmb[3] = n & M52;
        n        = (n >> 52) + d.lmb[4];
        q.lmb[4] = n & M48;
        q.acc    = {64'b0, n >> 48};
      end else if (s == 5) begin
        n        = (n << 32) + n * FOLD_LO_LOW + d.lmb[0];
        q.lmb[0] = n & M52;
        n        = (n >> 52) + d.lmb[1];
        q.lmb[1] = n & M52;
        q.acc    = {64'b0, n};
      end else if (s == 6) begin
        n        = (n >> 52) + d.lmb[2];
        q.lmb[2] = n & M52;
        n        = (n >> 52) + d.lmb[3];
        q.lmb[3] = n & M52;
        n        = (n >> 52) + d.lmb[4];
        q.lmb[4] = n & M48;
      end else if (s == 7) begin
        keep = (d.lmb[4] < P_LIMB4) | (d.lmb[3] < M52) | (d.lmb[2] < M52)
             | (d.lmb[1] < M52) | (d.lmb[0] < P_LIMB0);
        q.lmb[0] = keep ? d.lmb[0] : d.lmb[0] - P_LIMB0;
        for (int i = 1; i < 5; i++) begin
          q.lmb[i] = keep ? d.lmb[i] : '0;
        end
      end
    end
    return q;
  endfunction

  stg_t entry;
  stg_t pipe [1:BK_STAGES];
  logic vld  [1:BK_STAGES];

  // Entry record straight from the queue head.
  always_comb begin
    entry        = '0;
    entry.op     = in_work.op;
    entry.x      = in_work.x;
    entry.y      = in_work.y;
    entry.scalar = in_work.scalar;
  end

  // Valid flags of the pipeline stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= BK_STAGES; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[1] <= in_valid;
      for (int i = 2; i <= BK_STAGES; i++) begin
        vld[i] <= vld[i - 1];
      end
    end
  end

  // Pipeline stages.
  always_ff @(posedge clk) begin
    pipe[1] <= stage_fn(0, entry);
    for (int i = 1; i < BK_STAGES; i++) begin
      pipe[i + 1] <= stage_fn(i, pipe[i]);
    end
  end

  // Output register with flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[BK_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    result.res_limb0 <= pipe[BK_STAGES].lmb[0];
    result.res_limb1 <= pipe[BK_STAGES].lmb[1];
    result.res_limb2 <= pipe[BK_STAGES].lmb[2];
    result.res_limb3 <= pipe[BK_STAGES].lmb[3];
    result.res_limb4 <= pipe[BK_STAGES].lmb[4];
    result.is_zero   <= ~|pipe[BK_STAGES].lmb;
    result.is_odd    <= pipe[BK_STAGES].lmb[0][0];
  end

endmodule

>>> design/secp256k1_field_alu_unit.sv
// Arithmetic unit for the secp256k1 prime field, five 52-bit-radix limbs.
// Command channel: an item is taken at a rising edge with start high and
// busy low; item carries the operation selector, both operands and scalar.
// Result channel: done is high for one cycle with result valid; the
// receiver must take it then and cannot hold results off.
// Throughput: one item per cycle. Busy rises only when the internal queue
// is full, which does not happen in steady operation because the back end
// drains one entry every cycle.
// Path: every kind passes through the front register, the queue and
// each of the 20 back-end stages set by the schoolbook product, its
// 128-bit carry chain over nine columns and the five-step fold; the
// output register loads at the end of the last stage and drives done.
// Results leave in the order the items were accepted.
// Reset (rst, synchronous) empties the queue and clears all valid flags;
// no item is in flight afterwards and no clearing pass is needed.
module secp256k1_field_alu_unit #(
  parameter int QUEUE_DEPTH = sfa_pkg::Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sfa_pkg::alu_in_t  item,
  output logic              busy,
  output logic              done,
  output sfa_pkg::alu_res_t result
);
  import sfa_pkg::*;
`include "secp256k1_field_alu_unit_defines.svh"

  logic    push;
  work_t   push_data;
  q_stat_t q_stat;
  logic    pop;
  work_t   head;

  // Accept and classify.
  sfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue.
  sfa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .head      (head)
  );

  // Execution pipeline.
  sfa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop),
    .in_work  (head),
    .done     (done),
    .result   (result)
  );

  // Busy only ever comes from a full queue.
  `SFA_ASSERT_IMPL(a_busy_full, clk, rst, busy, q_stat.full)
  // Every result traces back to an earlier queue transfer through the back-end stages and the output register.
  `SFA_ASSERT_IMPL(a_done_latency, clk, rst, done, $past(pop, BK_STAGES + 1))
  // An empty queue with nothing pushed stays empty.
  `SFA_ASSERT_NEXT(a_empty_holds, clk, rst, q_stat.empty && !push, q_stat.empty)

endmodule
